[rtl/linear_probe_hash_table_core_macros.svh]
// Assertion macros for the hash table core.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LPHT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash table core: same-cycle check failed");

`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash table core: next-cycle check failed");

`else

`define LPHT_ASSERT_SAME(label, clk, rst, ante, cons)

`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/lpht_pkg.sv]
package lpht_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W   = KEY_W + VALUE_W;

   typedef enum logic [1:0] {
      CMD_INSERT       = 2'd0,
      CMD_LOOKUP       = 2'd1,
      CMD_REMOVE_KEY   = 2'd2,
      CMD_REMOVE_VALUE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0] probe_count;
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] occupancy;
   } result_type;

endpackage

[rtl/lpht_channel_if.sv]
interface lpht_req_if import lpht_pkg::*;;
   logic               valid;
   logic               ready;
   command_type        command;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, command, key, value, input ready);
   modport sink (input valid, command, key, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*;;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [VALUE_W-1:0] found_value;
   logic [COUNT_W-1:0] probe_count;
   logic [SLOT_W-1:0]  slot_index;
   logic [COUNT_W-1:0] occupancy;

   modport source (output valid, status, found_value, probe_count, slot_index, occupancy,
                   input ready);
   modport sink (input valid, status, found_value, probe_count, slot_index, occupancy,
                 output ready);
endinterface

[rtl/lpht_slot_ram.sv]
module lpht_slot_ram import lpht_pkg::*; (
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lpht_probe_ctrl.sv]
`include "linear_probe_hash_table_core_macros.svh"

module lpht_probe_ctrl import lpht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  command_type        req_command,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   output ram_req_type        ram_req,
   input  logic [WORD_W-1:0]  rd_data,
   output logic               res_valid,
   input  logic               res_ready,
   output result_type         res
);

   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   result_type         res_ff, res_in;

   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_val;
   logic               slot_live;
   logic               hit;
   logic [SLOT_W-1:0]  start_slot;

   assign rd_key    = rd_data[WORD_W-1:VALUE_W];
   assign rd_val    = rd_data[VALUE_W-1:0];
   assign slot_live = valid_ff[cur_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      val_ff <= val_in;
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      res_in     = res_ff;
      ram_req    = '0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      hit        = 1'b0;
      start_slot = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_command;
               key_in = req_key;
               val_in = req_value;
               if (req_command != CMD_REMOVE_VALUE) begin
                  start_slot = req_key[SLOT_W-1:0];
               end
               cur_in = start_slot;
               idx_in = '0;
               if (req_command == CMD_REMOVE_KEY && count_ff == '0) begin
                  res_in.status      = ST_NOT_FOUND;
                  res_in.found_value = '0;
                  res_in.probe_count = '0;
                  res_in.slot_index  = '0;
                  res_in.occupancy   = count_ff;
                  state_in = S_DONE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = start_slot;
                  state_in = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            case (cmd_ff)
               CMD_INSERT:       hit = !slot_live || rd_key == key_ff;
               CMD_LOOKUP:       hit = slot_live && rd_key == key_ff;
               CMD_REMOVE_KEY:   hit = slot_live && rd_key == key_ff;
               CMD_REMOVE_VALUE: hit = slot_live && rd_val == val_ff;
               default:          hit = 1'b0;
            endcase

            if (hit) begin
               res_in.status      = ST_OK;
               res_in.found_value = (cmd_ff == CMD_LOOKUP) ? rd_val : '0;
               res_in.probe_count = {1'b0, idx_ff} + COUNT_W'(1);
               res_in.slot_index  = cur_ff;
               if (cmd_ff == CMD_INSERT) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = cur_ff;
                  ram_req.wr_data = {key_ff, val_ff};
                  valid_in[cur_ff] = 1'b1;
                  if (!slot_live) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else if (cmd_ff != CMD_LOOKUP) begin
                  valid_in[cur_ff] = 1'b0;
                  count_in = count_ff - COUNT_W'(1);
               end
               res_in.occupancy = count_in;
               state_in = S_DONE;
            end else if (idx_ff == SLOT_W'(CAPACITY - 1)) begin
               res_in.status      = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
               res_in.found_value = '0;
               res_in.probe_count = COUNT_W'(CAPACITY);
               res_in.slot_index  = '0;
               res_in.occupancy   = count_ff;
               state_in = S_DONE;
            end else begin
               cur_in = cur_ff + SLOT_W'(1);
               idx_in = idx_ff + SLOT_W'(1);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cur_ff + SLOT_W'(1);
            end
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   // The entry count always tracks the number of live slots.
   `LPHT_ASSERT_SAME(count_matches_valid_a, clock, reset, 1'b1,
                     $countones(valid_ff) == count_ff)
   `LPHT_ASSERT_SAME(write_only_probe_a, clock, reset, ram_req.wr_en,
                     state_ff == S_PROBE && cmd_ff == CMD_INSERT)
   `LPHT_ASSERT_SAME(full_only_insert_a, clock, reset, res_valid && res.status == ST_FULL,
                     cmd_ff == CMD_INSERT && count_ff == COUNT_W'(CAPACITY))
   `LPHT_ASSERT_NEXT(accept_starts_work_a, clock, reset, req_valid && req_ready,
                     state_ff == S_PROBE || state_ff == S_DONE)

endmodule

[rtl/linear_probe_hash_table_core.sv]
// Channel    Direction  Contents
// req_chan   in         command, key, value
// rsp_chan   out        status, found_value, probe_count, slot_index, occupancy
//
// A transaction passes through an accept state, a probe state that reads the slots one
// after another through the single RAM read port, and a completion state.
// Remove by key on an empty table skips probing and goes straight to completion.
// Reset clears the slot valid bits and the entry count.
// A finished result waits in the output register, and the next request is
// accepted meanwhile; the controller holds its result until the register frees.
`include "linear_probe_hash_table_core_macros.svh"

module linear_probe_hash_table_core import lpht_pkg::*; (
   input logic        clock,
   input logic        reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan
);

   ram_req_type       ram_req;
   logic [WORD_W-1:0] rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;
   result_type        rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   lpht_slot_ram u_slot_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   lpht_probe_ctrl u_probe_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .req_key     (req_chan.key),
      .req_value   (req_chan.value),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.found_value = rsp_ff.found_value;
   assign rsp_chan.probe_count = rsp_ff.probe_count;
   assign rsp_chan.slot_index  = rsp_ff.slot_index;
   assign rsp_chan.occupancy   = rsp_ff.occupancy;

   `LPHT_ASSERT_NEXT(result_loads_reg_a, clock, reset, res_valid && res_ready, rsp_valid_ff)
   `LPHT_ASSERT_SAME(count_in_range_a, clock, reset, rsp_valid_ff,
                     rsp_ff.occupancy <= COUNT_W'(CAPACITY))
   `LPHT_ASSERT_SAME(probe_in_range_a, clock, reset, rsp_valid_ff,
                     rsp_ff.probe_count <= COUNT_W'(CAPACITY))

endmodule

[tb/tb_top.sv]
module tb_top;
   import lpht_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int KEY_POOL_N   = 96;
   localparam int VALUE_POOL_N = 12;
   localparam int HOLD_AT_ITEM = 400;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      command_type        command;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      result_type         want;
   } stim_row_type;

   localparam result_type FROM_PREDICTOR = '0;
   localparam logic [KEY_W-1:0] KEY_MAX  = '1;
   localparam int DIRECTED_ROWS = 22;

   stim_row_type directed_plan [DIRECTED_ROWS] = '{
      '{CMD_LOOKUP,       64'd0,   32'd0,        1'b1, '{ST_NOT_FOUND, 32'd0, 7'd64, 6'd0, 7'd0}},
      '{CMD_REMOVE_KEY,   64'd0,   32'd0,        1'b1, '{ST_NOT_FOUND, 32'd0, 7'd0, 6'd0, 7'd0}},
      '{CMD_REMOVE_VALUE, 64'd0,   32'hFFFFFFFF, 1'b1, '{ST_NOT_FOUND, 32'd0, 7'd64, 6'd0, 7'd0}},
      '{CMD_INSERT,       64'd0,   32'hFFFFFFFF, 1'b1, '{ST_OK, 32'd0, 7'd1, 6'd0, 7'd1}},
      '{CMD_INSERT,       KEY_MAX, 32'd0,        1'b1, '{ST_OK, 32'd0, 7'd1, 6'd63, 7'd2}},
      '{CMD_LOOKUP,       KEY_MAX, 32'd0,        1'b1, '{ST_OK, 32'd0, 7'd1, 6'd63, 7'd2}},
      '{CMD_LOOKUP,       64'd0,   32'd0,        1'b1,
        '{ST_OK, 32'hFFFFFFFF, 7'd1, 6'd0, 7'd2}},
      '{CMD_INSERT,       64'd64,  32'hA5A5A5A5, 1'b1, '{ST_OK, 32'd0, 7'd2, 6'd1, 7'd3}},
      '{CMD_INSERT,       64'd0,   32'd1,        1'b1, '{ST_OK, 32'd0, 7'd1, 6'd0, 7'd3}},
      '{CMD_INSERT,       64'd128, 32'h12345678, 1'b0, FROM_PREDICTOR},
      '{CMD_INSERT,       64'd127, 32'h5A5A5A5A, 1'b0, FROM_PREDICTOR},
      '{CMD_LOOKUP,       64'd128, 32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_LOOKUP,       64'd192, 32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_KEY,   64'd64,  32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_LOOKUP,       64'd128, 32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_VALUE, 64'd0,   32'hA5A5A5A5, 1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_VALUE, 64'd0,   32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_KEY,   KEY_MAX, 32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_INSERT,       64'd64,  32'hDEADBEEF, 1'b0, FROM_PREDICTOR},
      '{CMD_LOOKUP,       64'h8000_0000_0000_0040, 32'd0, 1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_KEY,   64'd0,   32'd0,        1'b0, FROM_PREDICTOR},
      '{CMD_REMOVE_VALUE, 64'd0,   32'h5A5A5A5A, 1'b0, FROM_PREDICTOR}
   };

   logic clock = 1'b0;
   logic reset;

   lpht_req_if req ();
   lpht_rsp_if rsp ();

   linear_probe_hash_table_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #6 clock = ~clock;

   logic [KEY_W-1:0]   table_keys   [CAPACITY];
   logic [VALUE_W-1:0] table_values [CAPACITY];
   bit                 table_used   [CAPACITY];
   int unsigned        table_count = 0;

   result_type pending_results [$];

   int items_sent    = 0;
   int results_seen  = 0;
   int fail_count    = 0;
   int cycle_count   = 0;
   int full_outcomes = 0;
   int miss_outcomes = 0;
   int hit_outcomes  = 0;
   bit hold_done     = 1'b0;

   logic steady;
   assign steady = (items_sent >= 700) && (items_sent < 1000);

   function automatic result_type apply_table_command(input command_type c,
                                                      input logic [KEY_W-1:0] k,
                                                      input logic [VALUE_W-1:0] v);
      result_type        r;
      logic [SLOT_W-1:0] s;
      bit                done;
      r.status      = ST_NOT_FOUND;
      r.found_value = '0;
      r.probe_count = COUNT_W'(CAPACITY);
      r.slot_index  = '0;
      done          = 1'b0;
      case (c)
         CMD_INSERT: begin
            r.status = ST_FULL;
            for (int i = 0; i < CAPACITY && !done; i++) begin
               s = k[SLOT_W-1:0] + SLOT_W'(i);
               if (!table_used[s] || table_keys[s] == k) begin
                  if (!table_used[s]) table_count++;
                  table_used[s]   = 1'b1;
                  table_keys[s]   = k;
                  table_values[s] = v;
                  r.status        = ST_OK;
                  r.probe_count   = COUNT_W'(i + 1);
                  r.slot_index    = s;
                  done            = 1'b1;
               end
            end
         end
         CMD_LOOKUP, CMD_REMOVE_KEY: begin
            if (c == CMD_REMOVE_KEY && table_count == 0) begin
               r.probe_count = '0;
            end else begin
               for (int i = 0; i < CAPACITY && !done; i++) begin
                  s = k[SLOT_W-1:0] + SLOT_W'(i);
                  if (table_used[s] && table_keys[s] == k) begin
                     r.status      = ST_OK;
                     r.probe_count = COUNT_W'(i + 1);
                     r.slot_index  = s;
                     done          = 1'b1;
                     if (c == CMD_LOOKUP) begin
                        r.found_value = table_values[s];
                     end else begin
                        table_used[s] = 1'b0;
                        table_count--;
                     end
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < CAPACITY && !done; i++) begin
               if (table_used[i] && table_values[i] == v) begin
                  table_used[i] = 1'b0;
                  if (table_count > 0) table_count--;
                  r.status      = ST_OK;
                  r.probe_count = COUNT_W'(i + 1);
                  r.slot_index  = SLOT_W'(i);
                  done          = 1'b1;
               end
            end
         end
      endcase
      r.occupancy = COUNT_W'(table_count);
      case (r.status)
         ST_OK:   hit_outcomes++;
         ST_FULL: full_outcomes++;
         default: miss_outcomes++;
      endcase
      return r;
   endfunction

   task automatic offer_request(input command_type c, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v, input bit typed,
                                input result_type want);
      result_type predicted;
      while (!steady && $urandom_range(0, 99) < 7) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.command <= c;
      req.key     <= k;
      req.value   <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predicted = apply_table_command(c, k, v);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[linear_probe_hash_table_core] ERROR");
         $finish;
      end
   end

   initial begin : response_side
      result_type want;
      int         hold_left;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("unexpected transaction: status %0d slot_index %0d", rsp.status,
                      rsp.slot_index);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp.status);
                  fail_count++;
               end
               if (rsp.found_value !== want.found_value) begin
                  $error("found_value: expected %h, actual %h", want.found_value,
                         rsp.found_value);
                  fail_count++;
               end
               if (rsp.probe_count !== want.probe_count) begin
                  $error("probe_count: expected %0d, actual %0d", want.probe_count,
                         rsp.probe_count);
                  fail_count++;
               end
               if (rsp.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, actual %0d", want.slot_index,
                         rsp.slot_index);
                  fail_count++;
               end
               if (rsp.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d", want.occupancy,
                         rsp.occupancy);
                  fail_count++;
               end
            end
         end
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (reset) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
         end
      end
   end

   initial begin : request_side
      logic [KEY_W-1:0]   key_pool   [KEY_POOL_N];
      logic [VALUE_W-1:0] value_pool [VALUE_POOL_N];
      command_type        c;
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      int                 mode;
      int                 pick;
      int                 w_ins;
      int                 w_look;
      int                 w_rkey;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.command <= CMD_INSERT;
      req.key     <= '0;
      req.value   <= '0;
      for (int i = 0; i < KEY_POOL_N; i++) begin
         key_pool[i] = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 1) key_pool[i][SLOT_W-1:0] = SLOT_W'($urandom_range(0, 7));
      end
      for (int i = 0; i < VALUE_POOL_N; i++) value_pool[i] = $urandom;
      value_pool[0] = '0;
      value_pool[1] = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         offer_request(directed_plan[r].command, directed_plan[r].key, directed_plan[r].value,
                       directed_plan[r].typed, directed_plan[r].want);
      end

      // Blocks of the random part alternate between filling, mixed traffic and draining,
      // so that both the full table and the empty table are reached repeatedly.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = (n / 150) % 3;
         case (mode)
            0: begin
               w_ins = 70; w_look = 15; w_rkey = 10;
            end
            1: begin
               w_ins = 35; w_look = 30; w_rkey = 25;
            end
            default: begin
               w_ins = 15; w_look = 20; w_rkey = 45;
            end
         endcase
         if ($urandom_range(0, 99) < 8) begin
            c = command_type'($urandom_range(0, 3));
            k = {$urandom, $urandom};
            v = $urandom;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < w_ins) c = CMD_INSERT;
            else if (pick < w_ins + w_look) c = CMD_LOOKUP;
            else if (pick < w_ins + w_look + w_rkey) c = CMD_REMOVE_KEY;
            else c = CMD_REMOVE_VALUE;
            k = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            v = ($urandom_range(0, 99) < 60) ? value_pool[$urandom_range(0, VALUE_POOL_N - 1)]
                                             : $urandom;
         end
         offer_request(c, k, v, 1'b0, FROM_PREDICTOR);
      end
      req.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Ran %0d requests and checked %0d responses against the table predictor.",
               items_sent, results_seen);
      $display("Outcomes: %0d ok, %0d not found, %0d table full.", hit_outcomes,
               miss_outcomes, full_outcomes);
      if (fail_count == 0) begin
         $display("[linear_probe_hash_table_core] OK");
      end else begin
         $display("[linear_probe_hash_table_core] ERROR");
      end
      $finish;
   end
endmodule
